// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the list block.
// Each macro samples on the rising edge of clk and is quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ilid_pkg.sv =====
`default_nettype none

package ilid_pkg;

	// Field widths of the request and result
	localparam int OPCODE_W = 3;
	localparam int POS_W    = 5;
	localparam int VALUE_W  = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Default storage shape
	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 16;

	// Operation codes
	localparam logic [OPCODE_W-1:0] OP_ADD_FRONT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD_REAR  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_REM_FRONT = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_REM_REAR  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_INS_AT    = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_REM_AT    = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// Row actions
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_INS  = 2'd1;
	localparam logic [1:0] ACT_DEL  = 2'd2;

	// Where the action lands
	localparam logic [1:0] SEL_FRONT = 2'd0;
	localparam logic [1:0] SEL_REAR  = 2'd1;
	localparam logic [1:0] SEL_POS   = 2'd2;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [POS_W-1:0]    position;
		logic [VALUE_W-1:0]  value;
	} ilid_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  removed_value;
		logic [COUNT_W-1:0]  count;
	} ilid_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic                load;
		logic [1:0]          act;
		logic [1:0]          sel;
		logic [STATUS_W-1:0] status;
	} ilid_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic ins_pos_ok;
		logic del_pos_ok;
	} ilid_dps_t;

endpackage

`default_nettype wire

// ===== sv/ilid_ctrl.sv =====
`default_nettype none

module ilid_ctrl
	import ilid_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire ilid_dps_t           dps,
	output ilid_cmd_t                cmd,
	output logic                     busy,
	output logic                     done
);

	`include "assert_macros.svh"

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RESP = 1'b1;

	logic state_q;
	logic accept;

	// The row finishes every request in the cycle it is taken
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Decide the action and the status of the request
	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.act    = ACT_NONE;
		cmd.sel    = SEL_FRONT;
		cmd.status = ST_OK;
		case (opcode)
			OP_ADD_FRONT, OP_ADD_REAR: begin
				cmd.sel = (opcode == OP_ADD_FRONT) ? SEL_FRONT : SEL_REAR;
				if (dps.full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.act = ACT_INS;
				end
			end
			OP_REM_FRONT, OP_REM_REAR: begin
				cmd.sel = (opcode == OP_REM_FRONT) ? SEL_FRONT : SEL_REAR;
				if (dps.empty) begin
					cmd.status = ST_UNDERFLOW;
				end else begin
					cmd.act = ACT_DEL;
				end
			end
			OP_INS_AT: begin
				cmd.sel = SEL_POS;
				if (!dps.ins_pos_ok) begin
					cmd.status = ST_RANGE;
				end else if (dps.full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.act = ACT_INS;
				end
			end
			OP_REM_AT: begin
				cmd.sel = SEL_POS;
				if (!dps.del_pos_ok) begin
					cmd.status = ST_RANGE;
				end else begin
					cmd.act = ACT_DEL;
				end
			end
			default: begin
				cmd.status = ST_RANGE;
			end
		endcase
		if (!accept) begin
			cmd.act = ACT_NONE;
		end
	end

	// Strobe the result in the cycle after each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: state_q <= accept ? ST_RESP : ST_IDLE;
				ST_RESP: state_q <= accept ? ST_RESP : ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = (state_q == ST_RESP);

	`ASSERT_IMPLIES(a_no_ins_full, cmd.act == ACT_INS, !dps.full, "insert commanded while full")
	`ASSERT_IMPLIES(a_no_del_empty, cmd.act == ACT_DEL, !dps.empty, "remove commanded while empty")
	`ASSERT_NEXT(a_done_follows, start && !busy, done, "result strobe missing after request")

endmodule

`default_nettype wire

// ===== sv/ilid_dp.sv =====
`default_nettype none

module ilid_dp
	import ilid_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ilid_req_t req,
	input  wire ilid_cmd_t cmd,
	output ilid_dps_t      dps,
	output ilid_rsp_t      rsp
);

	`include "assert_macros.svh"

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

	logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      len_next;
	logic [CMP_W-1:0]      pos_w;
	logic [CMP_W-1:0]      len_w;
	logic [CMP_W-1:0]      pos_m1;
	logic [LEN_W-1:0]      len_m1;
	logic [IDX_W-1:0]      idx;
	logic [DATA_WIDTH-1:0] val_in;
	logic [DATA_WIDTH-1:0] rd_data;
	logic [VALUE_W-1:0]    rd_ext;
	logic [COUNT_W-1:0]    count_ext;
	logic                  do_ins;
	logic                  do_del;
	ilid_rsp_t             rsp_q;

	assign do_ins = cmd.load && (cmd.act == ACT_INS);
	assign do_del = cmd.load && (cmd.act == ACT_DEL);

	// Checks against the current length
	assign pos_w          = CMP_W'(req.position);
	assign len_w          = CMP_W'(len_q);
	assign pos_m1         = pos_w - 1'b1;
	assign len_m1         = len_q - 1'b1;
	assign dps.empty      = (len_q == '0);
	assign dps.full       = (len_q == LEN_W'(CAPACITY));
	assign dps.ins_pos_ok = (pos_w != '0) && (pos_w <= len_w + 1'b1);
	assign dps.del_pos_ok = (pos_w != '0) && (pos_w <= len_w);

	// Pick the zero-based cell index
	always_comb begin
		case (cmd.sel)
			SEL_FRONT: idx = '0;
			SEL_REAR:  idx = (cmd.act == ACT_INS) ? len_q[IDX_W-1:0] : len_m1[IDX_W-1:0];
			SEL_POS:   idx = pos_m1[IDX_W-1:0];
			default:   idx = '0;
		endcase
	end

	// Fit the value and the removed element to the storage width
	generate
		if (DATA_WIDTH <= VALUE_W) begin : g_val_narrow
			assign val_in = req.value[DATA_WIDTH-1:0];
		end else begin : g_val_wide
			assign val_in = {{(DATA_WIDTH - VALUE_W){1'b0}}, req.value};
		end
		if (DATA_WIDTH >= VALUE_W) begin : g_rd_wide
			assign rd_ext = rd_data[VALUE_W-1:0];
		end else begin : g_rd_narrow
			assign rd_ext = {{(VALUE_W - DATA_WIDTH){1'b0}}, rd_data};
		end
		if (LEN_W >= COUNT_W) begin : g_cnt_wide
			assign count_ext = len_next[COUNT_W-1:0];
		end else begin : g_cnt_narrow
			assign count_ext = {{(COUNT_W - LEN_W){1'b0}}, len_next};
		end
	endgenerate

	assign rd_data = cell_q[idx];

	// Shift each cell toward or away from the index
	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [DATA_WIDTH-1:0] from_below;
			logic [DATA_WIDTH-1:0] from_above;
			if (g == 0) begin : g_first
				assign from_below = cell_q[0];
			end else begin : g_mid_lo
				assign from_below = cell_q[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign from_above = cell_q[g];
			end else begin : g_mid_hi
				assign from_above = cell_q[g+1];
			end
			always_ff @(posedge clk) begin
				if (do_ins && (IDX_W'(g) == idx)) begin
					cell_q[g] <= val_in;
				end else if (do_ins && (IDX_W'(g) > idx)) begin
					cell_q[g] <= from_below;
				end else if (do_del && (IDX_W'(g) >= idx)) begin
					cell_q[g] <= from_above;
				end
			end
		end
	endgenerate

	// Advance the length
	always_comb begin
		len_next = len_q;
		if (do_ins) begin
			len_next = len_q + 1'b1;
		end else if (do_del) begin
			len_next = len_m1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else begin
			len_q <= len_next;
		end
	end

	// Hold the result for the strobe cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.status        <= cmd.status;
			rsp_q.removed_value <= do_del ? rd_ext : '0;
			rsp_q.count         <= count_ext;
		end
	end

	assign rsp = rsp_q;

	`ASSERT_IMPLIES(a_len_cap, 1'b1, len_q <= LEN_W'(CAPACITY), "length above capacity")
	`ASSERT_NEXT(a_ins_grows, do_ins, len_q == $past(len_q) + 1'b1, "insert did not grow list")
	`ASSERT_NEXT(a_err_keeps, cmd.load && (cmd.status != ST_OK), $stable(len_q), "error changed length")

endmodule

`default_nettype wire

// ===== sv/indexed_list_insert_delete.sv =====
// Channel   Handshake         Payload
// request   start / busy      req : opcode, position, value
// result    done (strobe)     rsp : status, removed_value, count
//
// A request is taken on any edge with start high and busy low; busy stays low,
// so one request per cycle is sustained.
// Its result is on rsp, with done high, in the cycle after the request.
// The row of cells shifts the entries at and beyond the index toward or away from it as the request is taken.
// Reset clears the length and the strobe state; cell contents are unknown until written.
// The receiver cannot stall: each result is taken in its strobe cycle.
`default_nettype none

module indexed_list_insert_delete
	import ilid_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire ilid_req_t req,
	output logic           busy,
	output logic           done,
	output ilid_rsp_t      rsp
);

	ilid_cmd_t cmd;
	ilid_dps_t dps;

	ilid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (req.opcode),
		.dps    (dps),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ilid_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.dps    (dps),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
